// File: hw/rtl/bucketed_hash_set_top_assert.svh
// ----------------------------------------------------------------------------
// Bucketed hash set assertion macros
// Same-cycle-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_SET_TOP_ASSERT_SVH
`define BUCKETED_HASH_SET_TOP_ASSERT_SVH

// same-cycle implication
`define BHS_ASSERT_IMP(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BHS_ASSERT_NXT(lbl, clk, rst, ant, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed hash set package
// Shared widths, operation codes, defaults and transaction structs.
// ----------------------------------------------------------------------------
package bhs_pkg;

   localparam int unsigned KEY_W        = 20;
   localparam int unsigned FUNC_W       = 2;
   localparam int unsigned DEF_BUCKETS  = 769;
   localparam int unsigned DEF_WAYS     = 4;

   // operation codes; code 3 behaves as contains
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_REMOVE   = 2'd1,
      FUNC_CONTAINS = 2'd2
   } func_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic found;
      logic status;
   } rsp_type;

endpackage

// File: hw/rtl/bhs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bhs_index.sv
// ----------------------------------------------------------------------------
// Bucket index unit
// Four-stage pipeline: slot base = (key mod BUCKETS) * WAYS, using a
// reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module bhs_index #(
   parameter int unsigned BUCKETS = bhs_pkg::DEF_BUCKETS,
   parameter int unsigned WAYS    = bhs_pkg::DEF_WAYS
) (
   input  logic                                   clock,
   input  logic [bhs_pkg::KEY_W-1:0]              key,
   output logic [(((BUCKETS*WAYS) > 1) ? $clog2(BUCKETS*WAYS) : 1)-1:0] base
);

   import bhs_pkg::*;

   localparam int unsigned SLOTS   = BUCKETS * WAYS;
   localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned B_W     = $clog2(BUCKETS + 1);
   localparam int unsigned REM_W   = $clog2(2 * BUCKETS);
   localparam int unsigned RCP_W   = 33;
   localparam int unsigned SHIFT   = 32;
   localparam int unsigned PROD_W  = KEY_W + RCP_W;
   localparam int unsigned QB_W    = KEY_W + B_W;
   // floor(2^32 / BUCKETS): quotient estimate is low by at most one
   localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / BUCKETS);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [KEY_W-1:0]  key_d1_ff;
   logic [KEY_W-1:0]  quot;
   logic [QB_W-1:0]   qb;
   logic [KEY_W-1:0]  diff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [SLOT_W-1:0] base_ff, base_in;

   // stage 1: key times reciprocal
   assign prod_in = PROD_W'(key) * PROD_W'(RECIP);

   // stage 2: remainder estimate, below twice the bucket count
   assign quot = prod_ff[SHIFT+KEY_W-1:SHIFT];
   assign qb   = QB_W'(quot) * QB_W'(BUCKETS);
   assign diff = key_d1_ff - KEY_W'(qb);
   assign rem_in = REM_W'(diff);

   // stage 3: one correcting subtract
   always_comb begin
      if (rem_ff >= REM_W'(BUCKETS)) begin
         bucket_in = BKT_W'(rem_ff - REM_W'(BUCKETS));
      end else begin
         bucket_in = BKT_W'(rem_ff);
      end
   end

   // stage 4: scale to the first slot of the bucket
   assign base_in = SLOT_W'(SLOT_W'(bucket_ff) * SLOT_W'(WAYS));

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      key_d1_ff <= key;
      rem_ff    <= rem_in;
      bucket_ff <= bucket_in;
      base_ff   <= base_in;
   end

   assign base = base_ff;

endmodule

// File: hw/rtl/bucketed_hash_set_top.sv
// ----------------------------------------------------------------------------
// Bucketed hash set
// Set of 20-bit keys in BUCKETS buckets of WAYS slots, add/remove/contains.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The bucket index
// comes from a pipelined reciprocal-multiply unit, then one comparator scans
// the bucket's slots through the single read port of the slot RAM, one way per
// cycle, comparing each way once its registered read data returns, and the
// UPDATE state writes any change back. The result strobe rsp_valid lasts one
// cycle; it cannot be stalled, so the receiver must take it then. busy drops
// in that same cycle, so a new transaction can be taken as soon as the result
// is out; none is taken before. After reset the block clears every slot, one
// per cycle, and holds busy until the clearing pass ends before it takes its
// first transaction.
// ----------------------------------------------------------------------------
`include "bucketed_hash_set_top_assert.svh"

module bucketed_hash_set_top #(
   parameter int unsigned BUCKETS = bhs_pkg::DEF_BUCKETS,
   parameter int unsigned WAYS    = bhs_pkg::DEF_WAYS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bhs_pkg::req_type req_data,
   output logic             rsp_valid,
   output bhs_pkg::rsp_type rsp_data
);

   import bhs_pkg::*;

   localparam int unsigned SLOTS   = BUCKETS * WAYS;
   localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned WCNT_W  = $clog2(WAYS + 1);
   localparam int unsigned ENTRY_W = KEY_W + 1;
   localparam logic [1:0]  IDX_LAST = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_INDEX  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [1:0]        idx_cnt_ff, idx_cnt_in;
   logic [WCNT_W-1:0] rd_way_ff, rd_way_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [WAY_W-1:0]  cmp_way_ff, cmp_way_in;
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic              free_ff, free_in;
   logic [WAY_W-1:0]  free_way_ff, free_way_in;
   req_type           req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [SLOT_W-1:0]  base;
   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [SLOT_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               accept;
   logic               issue;
   logic               is_add;
   logic               is_remove;

   assign accept    = start && (state_ff == ST_IDLE);
   assign issue     = (state_ff == ST_SCAN) && (rd_way_ff != WCNT_W'(WAYS));
   assign is_add    = (req_ff.func == FUNC_ADD);
   assign is_remove = (req_ff.func == FUNC_REMOVE);

   // bucket index pipeline
   bhs_index #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_index (
      .clock (clock),
      .key   (req_ff.key),
      .base  (base)
   );

   // slot storage: {valid, key}
   bhs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = base + SLOT_W'(rd_way_ff);

   // write port: clearing pass or end-of-scan update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_UPDATE: begin
            if (is_add && !hit_ff && free_ff) begin
               wr_en   = 1'b1;
               wr_addr = base + SLOT_W'(free_way_ff);
               wr_data = {1'b1, req_ff.key};
            end else if (is_remove && hit_ff) begin
               wr_en   = 1'b1;
               wr_addr = base + SLOT_W'(hit_way_ff);
               wr_data = {1'b0, req_ff.key};
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      idx_cnt_in   = idx_cnt_ff;
      rd_way_in    = rd_way_ff;
      cmp_vld_in   = issue;
      cmp_way_in   = WAY_W'(rd_way_ff);
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      free_in      = free_ff;
      free_way_in  = free_way_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               idx_cnt_in = '0;
               state_in   = ST_INDEX;
            end
         end
         ST_INDEX: begin
            idx_cnt_in = idx_cnt_ff + 1'b1;
            if (idx_cnt_ff == IDX_LAST) begin
               rd_way_in = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_way_in = rd_way_ff + 1'b1;
            end
            // compare the way read in the previous cycle
            if (cmp_vld_ff) begin
               if (rd_data[KEY_W] && (rd_data[KEY_W-1:0] == req_ff.key)) begin
                  hit_in     = 1'b1;
                  hit_way_in = cmp_way_ff;
               end
               if (!rd_data[KEY_W] && !free_ff) begin
                  free_in     = 1'b1;
                  free_way_in = cmp_way_ff;
               end
               if (!issue) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            rsp_valid_in  = 1'b1;
            rsp_in.found  = hit_ff;
            rsp_in.status = is_add && !hit_ff && !free_ff;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      idx_cnt_ff  <= idx_cnt_in;
      rd_way_ff   <= rd_way_in;
      cmp_way_ff  <= cmp_way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `BHS_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `BHS_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "no busy after accept")
   `BHS_ASSERT_IMP(a_drop_absent, clock, reset, rsp_valid && rsp_data.status,
      !rsp_data.found, "dropped add reports found key")
   `BHS_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")

endmodule

// File: tb/bucketed_hash_set_top_tb.sv
// ----------------------------------------------------------------------------
// Bucketed hash set testbench
// Drives add, remove and contains transactions into the hash set and checks
// every response against a behavioral copy of the bucket table. A short
// directed run covers the edge keys, a full bucket and the spare opcode;
// random traffic then concentrates on a few crowded buckets so that
// collisions, drops and reuse of freed ways happen often.
// ----------------------------------------------------------------------------
module bucketed_hash_set_top_tb;
   import bhs_pkg::*;

   localparam int unsigned BUCKETS_N   = DEF_BUCKETS;
   localparam int unsigned WAYS_N      = DEF_WAYS;
   localparam int unsigned SLOT_COUNT  = BUCKETS_N * WAYS_N;
   localparam int unsigned RSP_LATENCY = WAYS_N + 7;
   localparam int unsigned KEY_MAX     = (1 << KEY_W) - 1;
   localparam int unsigned RANDOM_OPS  = 1330;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOT_COUNT   = 6;
   localparam int unsigned POOL_DEPTH  = 40;
   // spare opcode, behaves as contains
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   // Expected-response store plus a copy of the slot table
   class hash_set_scoreboard;
      logic [KEY_W-1:0] slot_key [SLOT_COUNT];
      bit               slot_valid [SLOT_COUNT];
      rsp_type          expected_q [$];
      int unsigned      errors;

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         errors = 0;
      endfunction

      // apply one accepted transaction to the table, queue its response
      function void note_request(req_type req);
         int unsigned base;
         int          hit;
         int          vacant;
         rsp_type     exp_rsp;
         base   = (req.key % BUCKETS_N) * WAYS_N;
         hit    = -1;
         vacant = -1;
         for (int w = 0; w < WAYS_N; w++) begin
            if (slot_valid[base + w]) begin
               if (hit < 0 && slot_key[base + w] == req.key) hit = w;
            end else if (vacant < 0) begin
               vacant = w;
            end
         end
         exp_rsp.found  = (hit >= 0);
         exp_rsp.status = 1'b0;
         case (req.func)
            FUNC_ADD: begin
               if (hit < 0) begin
                  if (vacant >= 0) begin
                     slot_key[base + vacant]   = req.key;
                     slot_valid[base + vacant] = 1'b1;
                  end else begin
                     exp_rsp.status = 1'b1;
                  end
               end
            end
            FUNC_REMOVE: begin
               if (hit >= 0) slot_valid[base + hit] = 1'b0;
            end
            default: ;
         endcase
         expected_q = {expected_q, exp_rsp};
      endfunction

      function void check_response(rsp_type act);
         rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("unexpected response: found=%0b status=%0b", act.found, act.status);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (act.found !== exp_rsp.found) begin
            $error("found mismatch: expected %0b, actual %0b", exp_rsp.found, act.found);
            errors++;
         end
         if (act.status !== exp_rsp.status) begin
            $error("status mismatch: expected %0b, actual %0b", exp_rsp.status, act.status);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   req_type     req_data = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   int unsigned cycle_count = 0;
   bit          idle_on     = 1'b1;

   hash_set_scoreboard sb = new();

   logic [KEY_W-1:0] key_pool [$];
   int unsigned      hot_bucket [HOT_COUNT];

   bucketed_hash_set_top #(
      .BUCKETS (BUCKETS_N),
      .WAYS    (WAYS_N)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Monitor: responses first, since an accept can share the response edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) sb.check_response(rsp_data);
         if (start === 1'b1 && busy === 1'b0) sb.note_request(req_data);
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 12);
      if (r < 97) return $urandom_range(13, 40);
      return $urandom_range(60, 150);
   endfunction

   // Present one transaction, hold it until taken, then idle for a while.
   // start stays high when no gap follows.
   task automatic send(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
      int unsigned gap;
      start         <= 1'b1;
      req_data.func <= func;
      req_data.key  <= key;
      do @(posedge clock); while (busy !== 1'b0);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every outstanding response has come back; the first
   // edge lets the monitor log a transaction taken at the calling edge
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned      r;
      int unsigned      b;
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  key;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: edge keys, present and absent cases, spare opcode
      send(FUNC_CONTAINS, '0);
      send(FUNC_ADD, '0);
      send(FUNC_ADD, '0);
      send(FUNC_CONTAINS, '0);
      send(FUNC_SPARE, '0);
      send(FUNC_ADD, KEY_W'(KEY_MAX));
      send(FUNC_REMOVE, KEY_W'(KEY_MAX));
      send(FUNC_REMOVE, KEY_W'(KEY_MAX));
      send(FUNC_CONTAINS, KEY_W'(KEY_MAX));
      // fill the last bucket, then overflow it
      for (int i = 0; i < WAYS_N + 1; i++) begin
         send(FUNC_ADD, KEY_W'(BUCKETS_N - 1 + BUCKETS_N * i));
      end
      send(FUNC_REMOVE, KEY_W'(2 * BUCKETS_N - 1));
      send(FUNC_ADD, KEY_W'(BUCKETS_N - 1 + BUCKETS_N * WAYS_N));
      send(FUNC_ADD, KEY_W'(2 * BUCKETS_N - 1));
      send(FUNC_CONTAINS, KEY_W'(3 * BUCKETS_N - 1));
      send(FUNC_REMOVE, '0);
      send(FUNC_SPARE, KEY_W'(KEY_MAX));
      // highest key that lands in the last bucket, into a full bucket
      send(FUNC_ADD,
           KEY_W'(BUCKETS_N - 1 + BUCKETS_N * ((KEY_MAX - (BUCKETS_N - 1)) / BUCKETS_N)));
      drain();

      // Random: crowded buckets, reuse of recent keys, some full-range keys
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 150 == 0) begin
            idle_on = ($urandom_range(0, 3) != 0);
            foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(0, BUCKETS_N - 1);
         end
         if (n == RANDOM_OPS / 2) drain();

         r = $urandom_range(0, 99);
         if (r < 40)      func = FUNC_ADD;
         else if (r < 65) func = FUNC_REMOVE;
         else if (r < 95) func = FUNC_CONTAINS;
         else             func = FUNC_SPARE;

         r = $urandom_range(0, 99);
         if (r < 50 && key_pool.size() != 0) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         end else if (r < 85) begin
            b   = hot_bucket[$urandom_range(0, HOT_COUNT - 1)];
            key = KEY_W'(b + BUCKETS_N * $urandom_range(0, (KEY_MAX - b) / BUCKETS_N));
         end else begin
            key = KEY_W'($urandom_range(0, KEY_MAX));
         end

         if (func == FUNC_ADD) begin
            key_pool = {key_pool, key};
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
         end
         send(func, key);
      end

      drain();
      repeat (RSP_LATENCY + 5) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
